// ===== rtl/core/qnf_pkg.sv =====
// ----------------------------------------------------------------------------
// qnf_pkg
// Shared sizes, codes, types and helpers of the quantized network evaluator.
// ----------------------------------------------------------------------------
package qnf_pkg;

  localparam int INPUT_WIDTH  = 512;
  localparam int SECOND_WIDTH = 32;
  localparam int THIRD_WIDTH  = 32;
  localparam int PHASES       = 8;
  localparam int LANES        = 8;
  localparam int GROUPS       = SECOND_WIDTH / LANES;

  localparam int IN_AW  = $clog2(INPUT_WIDTH);
  localparam int CNT_W  = $clog2(INPUT_WIDTH + 1);
  localparam int PH_W   = $clog2(PHASES);
  localparam int LANE_W = $clog2(LANES);
  localparam int GRP_W  = $clog2(GROUPS);
  localparam int S2_W   = $clog2(SECOND_WIDTH);
  localparam int S3_W   = $clog2(THIRD_WIDTH);
  localparam int J_W    = $clog2(((SECOND_WIDTH > THIRD_WIDTH) ? SECOND_WIDTH
                                                            : THIRD_WIDTH) + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int SUM_W     = 48;
  localparam int ACC_W     = 50;
  localparam int DIV_W     = 52;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = DIV_W / DIV_STEPS;
  localparam int DIVC_W    = $clog2(DIV_CYC + 1);

  localparam logic [2:0] SEL_B2 = 3'd0;
  localparam logic [2:0] SEL_W2 = 3'd1;
  localparam logic [2:0] SEL_B3 = 3'd2;
  localparam logic [2:0] SEL_W3 = 3'd3;
  localparam logic [2:0] SEL_WO = 3'd4;
  localparam logic [2:0] SEL_BO = 3'd5;

  localparam logic [2:0] REG_CLIP     = 3'd0;
  localparam logic [2:0] REG_SCR_DIV  = 3'd1;
  localparam logic [2:0] REG_L2_SCALE = 3'd2;
  localparam logic [2:0] REG_L3_SCALE = 3'd3;
  localparam logic [2:0] REG_FINAL    = 3'd4;

  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_LOAD,
    KIND_ELEM
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         phase;
    logic [2:0]         sel;
    logic [13:0]        idx;
    logic signed [47:0] value;
    logic signed [31:0] element;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [15:0] clip;
    logic [15:0] scr_div;
    logic [15:0] l2_scale;
    logic [15:0] l3_scale;
    logic [15:0] final_scale;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] mag;
    logic [15:0]      divisor;
  } div_req_t;

  function automatic logic [15:0] nz16(input logic [15:0] v);
    nz16 = (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    if (v[SUM_W] != v[SUM_W-1]) begin
      sat_sum = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = v[SUM_W-1:0];
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_quot(input logic signed [DIV_W-1:0] v);
    if (v[DIV_W-1:SUM_W-1] == '0 || v[DIV_W-1:SUM_W-1] == '1) begin
      sat_quot = v[SUM_W-1:0];
    end else begin
      sat_quot = v[DIV_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [15:0] relu16(input logic signed [DIV_W-1:0] v);
    if (v[DIV_W-1]) begin
      relu16 = 16'd0;
    end else if (|v[DIV_W-2:16]) begin
      relu16 = 16'hFFFF;
    end else begin
      relu16 = v[15:0];
    end
  endfunction

endpackage

// ===== rtl/core/qnf_div.sv =====
// ----------------------------------------------------------------------------
// qnf_div
// Shared sign-magnitude divider, four restoring steps per cycle.
// ----------------------------------------------------------------------------
module qnf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  qnf_pkg::div_req_t                req,
  output logic                             done,
  output logic signed [qnf_pkg::DIV_W-1:0] quot
);
  import qnf_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIVC_W-1:0] cnt_r;
  logic [DIV_W-1:0]  q_r;
  logic [DIV_W-1:0]  q_nxt;
  logic [15:0]       rem_r;
  logic [15:0]       rem_nxt;
  logic [15:0]       d_r;
  logic              neg_r;

  always_comb begin
    logic [16:0]      rem_v;
    logic [DIV_W-1:0] q_v;
    rem_v = {1'b0, rem_r};
    q_v   = q_r;
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_v = {rem_v[15:0], q_v[DIV_W-1]};
      q_v   = {q_v[DIV_W-2:0], 1'b0};
      if (rem_v >= {1'b0, d_r}) begin
        rem_v  = rem_v - {1'b0, d_r};
        q_v[0] = 1'b1;
      end
    end
    q_nxt   = q_v;
    rem_nxt = rem_v[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVC_W'(DIV_CYC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.mag;
      rem_r <= '0;
      d_r   <= req.divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// ===== rtl/core/qnf_front.sv =====
// ----------------------------------------------------------------------------
// qnf_front
// Request intake: classifies each request and queues it for the back end.
// ----------------------------------------------------------------------------
module qnf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [2:0]         in_phase,
  input  logic [2:0]         in_table_select,
  input  logic [13:0]        in_table_index,
  input  logic signed [47:0] in_table_value,
  input  logic signed [31:0] in_element_value,
  input  logic               in_last,
  output qnf_pkg::item_t     head,
  output logic               head_valid,
  input  logic               pop
);
  import qnf_pkg::*;

  item_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               push;
  logic               idx_ok;
  item_t              item;

  always_comb begin
    unique case (in_table_select)
      SEL_B2:  idx_ok = int'(in_table_index) < SECOND_WIDTH;
      SEL_W2:  idx_ok = int'(in_table_index) < SECOND_WIDTH * INPUT_WIDTH;
      SEL_B3:  idx_ok = int'(in_table_index) < THIRD_WIDTH;
      SEL_W3:  idx_ok = int'(in_table_index) < THIRD_WIDTH * SECOND_WIDTH;
      SEL_WO:  idx_ok = int'(in_table_index) < THIRD_WIDTH;
      SEL_BO:  idx_ok = in_table_index == 14'd0;
      default: idx_ok = 1'b0;
    endcase
  end

  always_comb begin
    item.phase   = in_phase;
    item.sel     = in_table_select;
    item.idx     = in_table_index;
    item.value   = in_table_value;
    item.element = in_element_value;
    item.last    = in_last;
    if (in_mode) begin
      item.kind = KIND_ELEM;
    end else if (idx_ok && int'(in_phase) < PHASES) begin
      item.kind = KIND_LOAD;
    end else begin
      item.kind = KIND_DROP;
    end
  end

  assign busy       = count_r == FIFO_CW'(FIFO_DEPTH);
  assign push       = start && !busy;
  assign head_valid = count_r != '0;
  assign head       = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== rtl/core/qnf_back.sv =====
// ----------------------------------------------------------------------------
// qnf_back
// Execution engine: table writes, eight-lane second layer, serial third and
// output layers, all scaling through the shared divider.
// ----------------------------------------------------------------------------
module qnf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  qnf_pkg::item_t                   head,
  input  logic                             head_valid,
  output logic                             pop,
  input  qnf_pkg::cfg_t                    cfg,
  output qnf_pkg::div_req_t                div_req,
  input  logic                             div_done,
  input  logic signed [qnf_pkg::DIV_W-1:0] div_quot,
  output logic                             out_valid,
  output logic signed [47:0]               out_score
);
  import qnf_pkg::*;

  localparam int W2A_W = PH_W + GRP_W + IN_AW;
  localparam int B2A_W = PH_W + GRP_W;
  localparam int W3A_W = PH_W + S3_W + S2_W;
  localparam int B3A_W = PH_W + S3_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'h0001,
    S_SQ   = 14'h0002,
    S_DIV  = 14'h0004,
    S_MAC  = 14'h0008,
    S_L2   = 14'h0010,
    S_L2R  = 14'h0020,
    S_L3B  = 14'h0040,
    S_L3M  = 14'h0080,
    S_L3D  = 14'h0100,
    S_L3R  = 14'h0200,
    S_OB   = 14'h0400,
    S_OM   = 14'h0800,
    S_OD   = 14'h1000,
    S_OUT  = 14'h2000
  } state_t;

  logic signed [7:0]  w2_mem [LANES][PHASES*GROUPS*INPUT_WIDTH];
  logic signed [31:0] b2_mem [LANES][PHASES*GROUPS];
  logic signed [7:0]  w3_mem [PHASES*THIRD_WIDTH*SECOND_WIDTH];
  logic signed [31:0] b3_mem [PHASES*THIRD_WIDTH];
  logic signed [7:0]  wo_mem [PHASES*THIRD_WIDTH];
  logic signed [47:0] bo_mem [PHASES];

  logic signed [7:0]  w2_q [LANES];
  logic signed [31:0] b2_q [LANES];
  logic signed [7:0]  w3_q;
  logic signed [31:0] b3_q;
  logic signed [7:0]  wo_q;
  logic signed [47:0] bo_q;

  state_t                   state_r;
  state_t                   ret_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [PH_W-1:0]          ph_r;
  logic signed [31:0]       elem_r;
  logic                     last_r;
  logic [30:0]              act_r;
  logic [J_W-1:0]           j_r;
  logic [S2_W-1:0]          k_r;
  logic [S3_W-1:0]          o_r;
  logic signed [SUM_W-1:0]  sums_r [SECOND_WIDTH];
  logic [15:0]              h2_r [SECOND_WIDTH];
  logic [15:0]              h3_r [THIRD_WIDTH];
  logic signed [ACC_W-1:0]  acc_r;
  logic                     div_start_r;
  logic                     div_neg_r;
  logic [DIV_W-1:0]         div_mag_r;
  logic [15:0]              div_dvsr_r;
  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_score_r;

  logic signed [SUM_W-1:0]  lane_sum [LANES];
  logic                     load_we;
  logic [PH_W-1:0]          wph;
  logic [S2_W-1:0]          w2_o;
  logic [S2_W-1:0]          b2_o;
  logic [15:0]              clamp_c;
  logic [31:0]              csq;
  logic signed [DIV_W-1:0]  sum0_x;
  logic signed [DIV_W-1:0]  acc_x;
  logic signed [24:0]       prod3;
  logic signed [24:0]       prodo;
  logic                     h2_shift;
  logic [15:0]              h2_in;
  logic                     h3_shift;
  logic [15:0]              h3_in;

  assign pop     = (state_r == S_IDLE) && head_valid;
  assign load_we = pop && (head.kind == KIND_LOAD);
  assign wph     = head.phase[PH_W-1:0];
  assign w2_o    = head.idx[IN_AW +: S2_W];
  assign b2_o    = head.idx[S2_W-1:0];

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (load_we) begin
      case (head.sel)
        SEL_B2: b2_mem[b2_o[LANE_W-1:0]][{wph, b2_o[LANE_W +: GRP_W]}] <= head.value[31:0];
        SEL_W2: w2_mem[w2_o[LANE_W-1:0]][{wph, w2_o[LANE_W +: GRP_W],
                                           head.idx[IN_AW-1:0]}] <= head.value[7:0];
        SEL_B3: b3_mem[{wph, head.idx[S3_W-1:0]}] <= head.value[31:0];
        SEL_W3: w3_mem[{wph, head.idx[S3_W+S2_W-1:0]}] <= head.value[7:0];
        SEL_WO: wo_mem[{wph, head.idx[S3_W-1:0]}] <= head.value[7:0];
        SEL_BO: bo_mem[wph] <= head.value;
        default: ;
      endcase
    end
    for (int l = 0; l < LANES; l++) begin
      w2_q[l] <= w2_mem[l][W2A_W'({ph_r, j_r[GRP_W-1:0], cnt_r[IN_AW-1:0]})];
      b2_q[l] <= b2_mem[l][B2A_W'({ph_r, j_r[GRP_W-1:0]})];
    end
    w3_q <= w3_mem[W3A_W'({ph_r, o_r, j_r[S2_W-1:0]})];
    b3_q <= b3_mem[B3A_W'({ph_r, o_r})];
    wo_q <= wo_mem[{ph_r, j_r[S3_W-1:0]}];
    bo_q <= bo_mem[ph_r];
  end

  always_comb begin
    logic signed [SUM_W-1:0] base;
    logic signed [39:0]      prod;
    for (int l = 0; l < LANES; l++) begin
      base        = (cnt_r == '0) ? SUM_W'(b2_q[l]) : sums_r[l];
      prod        = $signed({1'b0, act_r}) * w2_q[l];
      lane_sum[l] = sat_sum((SUM_W+1)'(base) + (SUM_W+1)'(prod));
    end
  end

  always_comb begin
    if (elem_r[31]) begin
      clamp_c = 16'd0;
    end else if (elem_r[30:0] > 31'(cfg.clip)) begin
      clamp_c = cfg.clip;
    end else begin
      clamp_c = elem_r[15:0];
    end
  end

  assign csq    = {16'd0, clamp_c} * {16'd0, clamp_c};
  assign sum0_x = DIV_W'(sums_r[0]);
  assign acc_x  = DIV_W'(acc_r);
  assign prod3  = $signed({1'b0, h2_r[0]}) * w3_q;
  assign prodo  = $signed({1'b0, h3_r[0]}) * wo_q;

  assign h2_shift = (state_r == S_L2R) || (state_r == S_L3M && j_r != '0);
  assign h2_in    = (state_r == S_L2R) ? relu16(div_quot) : h2_r[0];
  assign h3_shift = (state_r == S_L3R) || (state_r == S_OM && j_r != '0);
  assign h3_in    = (state_r == S_L3R) ? relu16(div_quot) : h3_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      ph_r        <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop && head.kind == KIND_ELEM) begin
            if (cnt_r == '0) begin
              ph_r <= head.phase[PH_W-1:0];
            end
            if (cnt_r < CNT_W'(INPUT_WIDTH)) begin
              state_r <= S_SQ;
            end else if (head.last) begin
              state_r <= S_L2;
            end
          end
        end
        S_SQ: begin
          div_start_r <= 1'b1;
          ret_r       <= S_MAC;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= ret_r;
          end
        end
        S_MAC: begin
          if (j_r == J_W'(GROUPS)) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= last_r ? S_L2 : S_IDLE;
          end
        end
        S_L2: begin
          div_start_r <= 1'b1;
          ret_r       <= S_L2R;
          state_r     <= S_DIV;
        end
        S_L2R: begin
          state_r <= (k_r == S2_W'(SECOND_WIDTH - 1)) ? S_L3B : S_L2;
        end
        S_L3B: state_r <= S_L3M;
        S_L3M: begin
          if (j_r == J_W'(SECOND_WIDTH)) begin
            state_r <= S_L3D;
          end
        end
        S_L3D: begin
          div_start_r <= 1'b1;
          ret_r       <= S_L3R;
          state_r     <= S_DIV;
        end
        S_L3R: begin
          state_r <= (o_r == S3_W'(THIRD_WIDTH - 1)) ? S_OB : S_L3B;
        end
        S_OB: state_r <= S_OM;
        S_OM: begin
          if (j_r == J_W'(THIRD_WIDTH)) begin
            state_r <= S_OD;
          end
        end
        S_OD: begin
          div_start_r <= 1'b1;
          ret_r       <= S_OUT;
          state_r     <= S_DIV;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          cnt_r       <= '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        elem_r <= head.element;
        last_r <= head.last;
        k_r    <= '0;
      end
      S_SQ: begin
        div_neg_r  <= 1'b0;
        div_mag_r  <= DIV_W'(csq);
        div_dvsr_r <= nz16(cfg.scr_div);
        j_r        <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          act_r <= (div_quot[DIV_W-1:31] != '0) ? 31'h7FFF_FFFF : div_quot[30:0];
        end
      end
      S_MAC: begin
        j_r <= j_r + 1'b1;
        // take the group read last cycle, rotate the next group to the front
        if (j_r != '0) begin
          for (int i = 0; i < SECOND_WIDTH - LANES; i++) begin
            sums_r[i] <= sums_r[i+LANES];
          end
          for (int l = 0; l < LANES; l++) begin
            sums_r[SECOND_WIDTH-LANES+l] <= lane_sum[l];
          end
        end
        k_r <= '0;
      end
      S_L2: begin
        div_neg_r  <= sum0_x[DIV_W-1];
        div_mag_r  <= sum0_x[DIV_W-1] ? -sum0_x : sum0_x;
        div_dvsr_r <= nz16(cfg.l2_scale);
        for (int i = 0; i < SECOND_WIDTH - 1; i++) begin
          sums_r[i] <= sums_r[i+1];
        end
        sums_r[SECOND_WIDTH-1] <= sums_r[0];
      end
      S_L2R: begin
        k_r <= k_r + 1'b1;
        o_r <= '0;
      end
      S_L3B: j_r <= '0;
      S_L3M: begin
        j_r   <= j_r + 1'b1;
        acc_r <= (j_r == '0) ? ACC_W'(b3_q) : acc_r + ACC_W'(prod3);
      end
      S_L3D, S_OD: begin
        div_neg_r  <= acc_x[DIV_W-1];
        div_mag_r  <= acc_x[DIV_W-1] ? -acc_x : acc_x;
        div_dvsr_r <= (state_r == S_OD) ? nz16(cfg.final_scale) : nz16(cfg.l3_scale);
      end
      S_L3R: o_r <= o_r + 1'b1;
      S_OB: j_r <= '0;
      S_OM: begin
        j_r   <= j_r + 1'b1;
        acc_r <= (j_r == '0) ? ACC_W'(bo_q) : acc_r + ACC_W'(prodo);
      end
      S_OUT: out_score_r <= sat_quot(div_quot);
      default: ;
    endcase
    if (h2_shift) begin
      for (int i = 0; i < SECOND_WIDTH - 1; i++) begin
        h2_r[i] <= h2_r[i+1];
      end
      h2_r[SECOND_WIDTH-1] <= h2_in;
    end
    if (h3_shift) begin
      for (int i = 0; i < THIRD_WIDTH - 1; i++) begin
        h3_r[i] <= h3_r[i+1];
      end
      h3_r[THIRD_WIDTH-1] <= h3_in;
    end
  end

  assign div_req   = {div_start_r, div_neg_r, div_mag_r, div_dvsr_r};
  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

endmodule

// ===== rtl/core/quantized_nnue_forward_top.sv =====
// ----------------------------------------------------------------------------
// quantized_nnue_forward_top
// Per-phase quantized three-layer evaluator with configuration registers.
// ----------------------------------------------------------------------------
// Table loads are written as they leave the queue; a dense element passes
// through intake, squaring, the shared 4-bit-per-cycle divider and the
// eight-lane MAC. The last element adds serial second-layer scaling and
// third/output layer work; out_valid then strobes, and the receiver cannot
// stall. A four-entry queue sets busy. Reset clears control and restores
// register defaults; tables stay unknown.
module quantized_nnue_forward_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [2:0]         in_phase,
  input  logic [2:0]         in_table_select,
  input  logic [13:0]        in_table_index,
  input  logic signed [47:0] in_table_value,
  input  logic signed [31:0] in_element_value,
  input  logic               in_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic signed [47:0] out_score
);
  import qnf_pkg::*;

  cfg_t                    cfg_r;
  item_t                   head;
  logic                    head_valid;
  logic                    pop;
  div_req_t                div_req;
  logic                    div_done;
  logic signed [DIV_W-1:0] div_quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip        <= 16'd181;
      cfg_r.scr_div     <= 16'd128;
      cfg_r.l2_scale    <= 16'd2;
      cfg_r.l3_scale    <= 16'd8;
      cfg_r.final_scale <= 16'd128;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLIP:     cfg_r.clip        <= cfg_data;
        REG_SCR_DIV:  cfg_r.scr_div     <= cfg_data;
        REG_L2_SCALE: cfg_r.l2_scale    <= cfg_data;
        REG_L3_SCALE: cfg_r.l3_scale    <= cfg_data;
        REG_FINAL:    cfg_r.final_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  qnf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_phase         (in_phase),
    .in_table_select  (in_table_select),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .in_element_value (in_element_value),
    .in_last          (in_last),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop)
  );

  qnf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (cfg_r),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_quot   (div_quot),
    .out_valid  (out_valid),
    .out_score  (out_score)
  );

  qnf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule
